// ===== sv/wkbp_pkg.sv =====
package wkbp_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam logic [2:0] KIND_COORD = 3'd0;
    localparam logic [2:0] KIND_RING  = 3'd1;
    localparam logic [2:0] KIND_PART  = 3'd2;
    localparam logic [2:0] KIND_DONE  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BYTE_ORD = 3'd1;
    localparam logic [2:0] ERR_TYPE     = 3'd2;
    localparam logic [2:0] ERR_SUBTYPE  = 3'd3;
    localparam logic [2:0] ERR_TRUNC    = 3'd4;

    localparam logic [2:0] T_POINT  = 3'd1;
    localparam logic [2:0] T_LINE   = 3'd2;
    localparam logic [2:0] T_POLY   = 3'd3;
    localparam logic [2:0] T_MPOINT = 3'd4;
    localparam logic [2:0] T_MLINE  = 3'd5;
    localparam logic [2:0] T_MPOLY  = 3'd6;

    localparam logic [31:0] ISO_Z_BASE = 32'd1000;
    localparam logic [31:0] OGC_Z_FLAG = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  gtype;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic        has_z;
        logic [31:0] idx;
        logic [2:0]  err;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0] n;
        rec_t       r0;
        rec_t       r1;
    } push_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] t;
        logic       z;
    } dtype_t;

    function automatic dtype_t decode_type(input logic [31:0] raw);
        dtype_t      d;
        logic [31:0] t;
        if (raw > ISO_Z_BASE && raw <= ISO_Z_BASE + 32'd6) begin
            t = raw - ISO_Z_BASE;
            d.z = 1'b1;
        end else if ((raw & OGC_Z_FLAG) != 32'd0) begin
            t = raw & ~OGC_Z_FLAG;
            d.z = 1'b1;
        end else begin
            t = raw;
            d.z = 1'b0;
        end
        d.ok = (t >= 32'd1) && (t <= 32'd6);
        d.t = t[2:0];
        return d;
    endfunction

    function automatic rec_t mk_rec(input logic [2:0] kind, input logic [2:0] gtype,
                                    input logic [63:0] x, input logic [63:0] y,
                                    input logic [63:0] z, input logic has_z,
                                    input logic [31:0] idx, input logic [2:0] err);
        rec_t r;
        r.kind = kind;
        r.gtype = gtype;
        r.x = x;
        r.y = y;
        r.z = z;
        r.has_z = has_z;
        r.idx = idx;
        r.err = err;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/wkbp_front.sv =====
module wkbp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output wkbp_pkg::push_t     push
);

    typedef enum logic [3:0] {
        PH_TOP_BO, PH_TOP_TYPE, PH_SUB_BO, PH_SUB_TYPE, PH_NUM_COORDS, PH_NUM_RINGS,
        PH_RING_COORDS, PH_NUM_PARTS, PH_X, PH_Y, PH_Z, PH_IDLE
    } phase_t;

    localparam int CW = wkbp_pkg::COUNT_WIDTH;

    phase_t          ph_reg, ph_next;
    logic            le_reg, le_next;
    logic [63:0]     fs_reg, fs_next;
    logic [2:0]      fc_reg, fc_next;
    logic [2:0]      tt_reg, tt_next;
    logic            hz_reg, hz_next;
    logic [31:0]     pl_reg, pl_next;
    logic [31:0]     rl_reg, rl_next;
    logic [31:0]     cl_reg, cl_next;
    logic [CW-1:0]   cc_reg, cc_next;
    logic [CW-1:0]   rc_reg, rc_next;
    logic [63:0]     xh_reg, xh_next;
    logic [63:0]     yh_reg, yh_next;
    logic            fin_reg, fin_next;

    wkbp_pkg::rec_t   recs [2];
    logic [1:0]       n;
    logic             leaf, npd, fin_req, collect, fdone;
    logic [3:0]       cplus;
    logic [63:0]      asm_v;
    wkbp_pkg::dtype_t dt;

    always_comb
    begin
        ph_next = ph_reg;
        le_next = le_reg;
        fs_next = fs_reg;
        fc_next = fc_reg;
        tt_next = tt_reg;
        hz_next = hz_reg;
        pl_next = pl_reg;
        rl_next = rl_reg;
        cl_next = cl_reg;
        cc_next = cc_reg;
        rc_next = rc_reg;
        xh_next = xh_reg;
        yh_next = yh_reg;
        fin_next = fin_reg;
        recs[0] = '0;
        recs[1] = '0;
        n = 2'd0;
        leaf = 1'b0;
        npd = 1'b0;
        fin_req = 1'b0;

        cplus = {1'b0, fc_reg} + 4'd1;
        if (ph_reg == PH_X || ph_reg == PH_Y || ph_reg == PH_Z)
            fdone = (cplus >= 4'd8);
        else
            fdone = (cplus >= 4'd4);
        if (le_reg)
            asm_v = fs_reg | (64'(data_byte) << {fc_reg, 3'b000});
        else
            asm_v = {fs_reg[55:0], data_byte};
        dt = wkbp_pkg::decode_type(asm_v[31:0]);
        collect = !(ph_reg == PH_TOP_BO || ph_reg == PH_SUB_BO || ph_reg == PH_IDLE);

        if (!fin_reg)
        begin
            if (collect && !fdone)
            begin
                fs_next = asm_v;
                fc_next = cplus[2:0];
            end
            else
            begin
                if (collect)
                begin
                    fs_next = '0;
                    fc_next = '0;
                end
                unique case (ph_reg)
                    PH_TOP_BO, PH_SUB_BO:
                    begin
                        if (data_byte > 8'd1)
                        begin
                            recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_ERROR, tt_next, '0, '0,
                                '0, 1'b0, '0, wkbp_pkg::ERR_BYTE_ORD);
                            n = n + 2'd1;
                            fin_next = 1'b1;
                            ph_next = PH_IDLE;
                        end
                        else
                        begin
                            le_next = (data_byte == 8'd1);
                            fs_next = '0;
                            fc_next = '0;
                            ph_next = (ph_reg == PH_TOP_BO) ? PH_TOP_TYPE : PH_SUB_TYPE;
                        end
                    end
                    PH_TOP_TYPE:
                    begin
                        if (!dt.ok)
                        begin
                            recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_ERROR, tt_next, '0, '0,
                                '0, 1'b0, '0, wkbp_pkg::ERR_TYPE);
                            n = n + 2'd1;
                            fin_next = 1'b1;
                            ph_next = PH_IDLE;
                        end
                        else
                        begin
                            tt_next = dt.t;
                            hz_next = dt.z;
                            if (dt.t == wkbp_pkg::T_POINT)
                            begin
                                cl_next = 32'd1;
                                ph_next = PH_X;
                            end
                            else if (dt.t == wkbp_pkg::T_LINE)
                                ph_next = PH_NUM_COORDS;
                            else if (dt.t == wkbp_pkg::T_POLY)
                                ph_next = PH_NUM_RINGS;
                            else
                                ph_next = PH_NUM_PARTS;
                        end
                    end
                    PH_SUB_TYPE:
                    begin
                        if (!dt.ok)
                        begin
                            recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_ERROR, tt_next, '0, '0,
                                '0, 1'b0, '0, wkbp_pkg::ERR_TYPE);
                            n = n + 2'd1;
                            fin_next = 1'b1;
                            ph_next = PH_IDLE;
                        end
                        else if ({1'b0, dt.t} + 4'd3 != {1'b0, tt_next})
                        begin
                            recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_ERROR, tt_next, '0, '0,
                                '0, 1'b0, '0, wkbp_pkg::ERR_SUBTYPE);
                            n = n + 2'd1;
                            fin_next = 1'b1;
                            ph_next = PH_IDLE;
                        end
                        else
                        begin
                            hz_next = dt.z;
                            if (dt.t == wkbp_pkg::T_POINT)
                            begin
                                cl_next = 32'd1;
                                ph_next = PH_X;
                            end
                            else if (dt.t == wkbp_pkg::T_LINE)
                                ph_next = PH_NUM_COORDS;
                            else
                            begin
                                recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_PART, tt_next, '0,
                                    '0, '0, 1'b0, 32'(rc_next), wkbp_pkg::ERR_NONE);
                                n = n + 2'd1;
                                ph_next = PH_NUM_RINGS;
                            end
                        end
                    end
                    PH_NUM_COORDS:
                    begin
                        if (tt_next == wkbp_pkg::T_MLINE)
                        begin
                            recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_RING, tt_next, '0, '0,
                                '0, 1'b0, 32'(cc_next), wkbp_pkg::ERR_NONE);
                            n = n + 2'd1;
                            rc_next = rc_next + 1'b1;
                        end
                        cl_next = asm_v[31:0];
                        if (asm_v[31:0] == 32'd0)
                            leaf = 1'b1;
                        else
                            ph_next = PH_X;
                    end
                    PH_NUM_RINGS:
                    begin
                        rl_next = asm_v[31:0];
                        cl_next = '0;
                        if (asm_v[31:0] == 32'd0)
                            leaf = 1'b1;
                        else
                            ph_next = PH_RING_COORDS;
                    end
                    PH_RING_COORDS:
                    begin
                        if (rl_next != 32'd0)
                            rl_next = rl_next - 32'd1;
                        recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_RING, tt_next, '0, '0,
                            '0, 1'b0, 32'(cc_next), wkbp_pkg::ERR_NONE);
                        n = n + 2'd1;
                        rc_next = rc_next + 1'b1;
                        cl_next = asm_v[31:0];
                        if (asm_v[31:0] == 32'd0)
                            leaf = 1'b1;
                        else
                            ph_next = PH_X;
                    end
                    PH_NUM_PARTS:
                    begin
                        pl_next = asm_v[31:0];
                        npd = 1'b1;
                    end
                    PH_X:
                    begin
                        xh_next = asm_v;
                        ph_next = PH_Y;
                    end
                    PH_Y, PH_Z:
                    begin
                        if (ph_reg == PH_Y)
                            yh_next = asm_v;
                        if (ph_reg == PH_Y && hz_next)
                            ph_next = PH_Z;
                        else
                        begin
                            recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_COORD, tt_next,
                                xh_next, yh_next, (ph_reg == PH_Z) ? asm_v : 64'd0, hz_next,
                                32'(cc_next), wkbp_pkg::ERR_NONE);
                            n = n + 2'd1;
                            cc_next = cc_next + 1'b1;
                            if (cl_next != 32'd0)
                                cl_next = cl_next - 32'd1;
                            if (cl_next == 32'd0)
                                leaf = 1'b1;
                            else
                                ph_next = PH_X;
                        end
                    end
                    default:
                    begin
                        ph_next = PH_IDLE;
                        fin_next = 1'b1;
                    end
                endcase

                // End of a coordinate run: move on to the next ring, part or finish.
                if (leaf)
                begin
                    if (tt_next == wkbp_pkg::T_POLY)
                    begin
                        if (rl_next != 32'd0)
                            ph_next = PH_RING_COORDS;
                        else
                            fin_req = 1'b1;
                    end
                    else if (tt_next == wkbp_pkg::T_MPOINT || tt_next == wkbp_pkg::T_MLINE)
                        npd = 1'b1;
                    else if (tt_next == wkbp_pkg::T_MPOLY)
                    begin
                        if (rl_next != 32'd0)
                            ph_next = PH_RING_COORDS;
                        else
                            npd = 1'b1;
                    end
                    else
                        fin_req = 1'b1;
                end
                if (npd)
                begin
                    if (pl_next != 32'd0)
                    begin
                        pl_next = pl_next - 32'd1;
                        ph_next = PH_SUB_BO;
                    end
                    else
                        fin_req = 1'b1;
                end
                if (fin_req)
                begin
                    recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_DONE, tt_next, '0, '0, '0,
                        1'b0, 32'(cc_next), wkbp_pkg::ERR_NONE);
                    n = n + 2'd1;
                    fin_next = 1'b1;
                    ph_next = PH_IDLE;
                end
            end
        end

        if (last_byte)
        begin
            if (!fin_next && n < 2'd2)
            begin
                recs[n[0]] = wkbp_pkg::mk_rec(wkbp_pkg::KIND_ERROR, tt_next, '0, '0, '0,
                    1'b0, '0, wkbp_pkg::ERR_TRUNC);
                n = n + 2'd1;
            end
            ph_next = PH_TOP_BO;
            le_next = 1'b1;
            fs_next = '0;
            fc_next = '0;
            tt_next = '0;
            hz_next = 1'b0;
            pl_next = '0;
            rl_next = '0;
            cl_next = '0;
            cc_next = '0;
            rc_next = '0;
            xh_next = '0;
            yh_next = '0;
            fin_next = 1'b0;
        end

        if (n == 2'd1)
            recs[0].last = 1'b1;
        else if (n == 2'd2)
            recs[1].last = 1'b1;

        push.n = n;
        push.r0 = recs[0];
        push.r1 = recs[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_TOP_BO;
            le_reg <= 1'b1;
            fs_reg <= '0;
            fc_reg <= '0;
            tt_reg <= '0;
            hz_reg <= 1'b0;
            pl_reg <= '0;
            rl_reg <= '0;
            cl_reg <= '0;
            cc_reg <= '0;
            rc_reg <= '0;
            xh_reg <= '0;
            yh_reg <= '0;
            fin_reg <= 1'b0;
        end
        else if (take)
        begin
            ph_reg <= ph_next;
            le_reg <= le_next;
            fs_reg <= fs_next;
            fc_reg <= fc_next;
            tt_reg <= tt_next;
            hz_reg <= hz_next;
            pl_reg <= pl_next;
            rl_reg <= rl_next;
            cl_reg <= cl_next;
            cc_reg <= cc_next;
            rc_reg <= rc_next;
            xh_reg <= xh_next;
            yh_reg <= yh_next;
            fin_reg <= fin_next;
        end
    end

endmodule

// ===== sv/wkbp_queue.sv =====
module wkbp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_en,
    input  wkbp_pkg::push_t    push,
    output logic               room,
    output logic               head_valid,
    input  logic               pop,
    output wkbp_pkg::rec_t     head
);

    wkbp_pkg::rec_t mem [4];
    logic [1:0]     wp_reg, wp_next;
    logic [1:0]     rp_reg, rp_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic [1:0]     nw;
    logic           do_pop;

    // Two free entries are needed since one word can make two records.
    assign room = (cnt_reg <= 3'd2);
    assign head_valid = (cnt_reg != 3'd0);
    assign head = mem[rp_reg];
    assign do_pop = pop && head_valid;
    assign nw = push_en ? push.n : 2'd0;

    always_comb
    begin
        wp_next = wp_reg + nw;
        rp_next = rp_reg + {1'b0, do_pop};
        cnt_next = cnt_reg + {1'b0, nw} - {2'b00, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (nw != 2'd0)
            mem[wp_reg] <= push.r0;
        if (nw == 2'd2)
            mem[wp_reg + 2'd1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== sv/wkb_geometry_stream_parser_unit.sv =====
// Channel  | Direction | Handshake          | Payload
// input    | in        | in_valid/in_stall  | data_byte, last_byte
// output   | out       | out_valid/out_stall| record_kind .. last_result
//
// One byte is taken per cycle while in_stall is low; its records reach the output from the next cycle on.
// Each byte makes zero, one or two records; the four-entry record queue drains one a cycle while
// out_stall is low, so bytes flow at one a cycle unless records pile up faster than they leave.
// in_stall rises while fewer than two queue entries are free.
// Reset clears the parser to expect a top-level byte order and empties the queue.
module wkb_geometry_stream_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  record_kind,
    output logic [2:0]  geom_type,
    output logic [63:0] x_bits,
    output logic [63:0] y_bits,
    output logic [63:0] z_bits,
    output logic        coord_has_z,
    output logic [31:0] index_value,
    output logic [2:0]  error_code,
    output logic        last_result
);

    wkbp_pkg::push_t push;
    wkbp_pkg::rec_t  head;
    logic            room;
    logic            take;

    assign in_stall = !room;
    assign take = in_valid && room;

    wkbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push)
    );

    wkbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (take),
        .push       (push),
        .room       (room),
        .head_valid (out_valid),
        .pop        (!out_stall),
        .head       (head)
    );

    assign record_kind = head.kind;
    assign geom_type = head.gtype;
    assign x_bits = head.x;
    assign y_bits = head.y;
    assign z_bits = head.z;
    assign coord_has_z = head.has_z;
    assign index_value = head.idx;
    assign error_code = head.err;
    assign last_result = head.last;

endmodule

// ===== sv/wkbp_checker.sv =====
module wkbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  record_kind,
    input logic [63:0] x_bits,
    input logic [63:0] y_bits,
    input logic [63:0] z_bits,
    input logic        coord_has_z,
    input logic [2:0]  error_code
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_bits) && $stable(record_kind))
        else $error("stalled output word changed");

    a_coord_noerr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == wkbp_pkg::KIND_COORD |-> error_code == wkbp_pkg::ERR_NONE)
        else $error("coordinate word carries an error code");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (record_kind == wkbp_pkg::KIND_DONE || record_kind == wkbp_pkg::KIND_ERROR)
        |-> x_bits == 64'd0 && y_bits == 64'd0)
        else $error("done or error word carries coordinates");

    a_no_z: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !coord_has_z |-> z_bits == 64'd0)
        else $error("z bits set without z flag");

endmodule

bind wkb_geometry_stream_parser_unit wkbp_checker u_wkbp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .record_kind (record_kind),
    .x_bits      (x_bits),
    .y_bits      (y_bits),
    .z_bits      (z_bits),
    .coord_has_z (coord_has_z),
    .error_code  (error_code)
);

// ===== tb/tb_wkb_geometry_stream_parser_unit.sv =====
`timescale 1ns / 100ps

module tb_wkb_geometry_stream_parser_unit;

    typedef enum logic [3:0] {
        P_TOP_BO, P_TOP_TYPE, P_SUB_BO, P_SUB_TYPE, P_NUM_COORDS, P_NUM_RINGS,
        P_RING_COORDS, P_NUM_PARTS, P_X, P_Y, P_Z, P_IDLE
    } phase_t;

    typedef enum int {FLAW_NONE, FLAW_BYTE_ORD, FLAW_TYPE, FLAW_SUBTYPE, FLAW_CUT,
                      FLAW_HUGE, FLAW_TAIL, FLAW_NOISE} flaw_t;

    typedef struct {
        logic [7:0] b;
        logic       l;
        bit         chk;
        logic [2:0] kind;
        logic [2:0] err;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  record_kind;
    logic [2:0]  geom_type;
    logic [63:0] x_bits;
    logic [63:0] y_bits;
    logic [63:0] z_bits;
    logic        coord_has_z;
    logic [31:0] index_value;
    logic [2:0]  error_code;
    logic        last_result;

    wkb_geometry_stream_parser_unit uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Parser state as the predictor sees it.
    phase_t      ph;
    bit          le;
    logic [63:0] shf;
    int          nbytes;
    logic [2:0]  ttype;
    bit          cur_z;
    logic [31:0] parts_left, rings_left, coords_left, coord_cnt, ring_cnt;
    logic [63:0] x_hold, y_hold;
    bit          done_flag;

    wkbp_pkg::rec_t step_recs[$];
    wkbp_pkg::rec_t record_q[$];
    int   fail_cnt = 0;
    bit   calm = 0;
    int   calm_from = -1;
    bit   hold_req = 0;
    bit   held = 0;
    bit   drained = 0;
    int   hold_cnt = 0;

    function automatic void add_rec(logic [2:0] kind, logic [63:0] x, logic [63:0] y,
                                    logic [63:0] z, bit h, logic [31:0] idx,
                                    logic [2:0] err);
        wkbp_pkg::rec_t r;
        if (step_recs.size() >= 2) return;
        r.kind = kind; r.gtype = ttype; r.x = x; r.y = y; r.z = z;
        r.has_z = h; r.idx = idx; r.err = err; r.last = 1'b0;
        step_recs.push_back(r);
    endfunction

    function automatic void abort_geom(logic [2:0] code);
        add_rec(wkbp_pkg::KIND_ERROR, 0, 0, 0, 0, 0, code);
        done_flag = 1;
        ph = P_IDLE;
    endfunction

    function automatic void close_geom();
        add_rec(wkbp_pkg::KIND_DONE, 0, 0, 0, 0, coord_cnt, wkbp_pkg::ERR_NONE);
        done_flag = 1;
        ph = P_IDLE;
    endfunction

    function automatic void clear_parser();
        ph = P_TOP_BO; le = 1; shf = 0; nbytes = 0; ttype = 0; cur_z = 0;
        parts_left = 0; rings_left = 0; coords_left = 0; coord_cnt = 0; ring_cnt = 0;
        x_hold = 0; y_hold = 0; done_flag = 0;
    endfunction

    function automatic bit gather(logic [7:0] b, int n, output logic [63:0] v);
        int c;
        c = nbytes;
        v = 0;
        if (le) shf = shf | (64'(b) << (8 * c));
        else shf = (shf << 8) | 64'(b);
        c++;
        if (c >= n)
        begin
            v = shf; shf = 0; nbytes = 0;
            return 1;
        end
        nbytes = c;
        return 0;
    endfunction

    function automatic void next_part();
        if (parts_left > 0)
        begin
            parts_left--;
            ph = P_SUB_BO;
        end
        else close_geom();
    endfunction

    function automatic void run_end();
        case (ttype)
            wkbp_pkg::T_POLY: if (rings_left > 0) ph = P_RING_COORDS; else close_geom();
            wkbp_pkg::T_MPOINT, wkbp_pkg::T_MLINE: next_part();
            wkbp_pkg::T_MPOLY: if (rings_left > 0) ph = P_RING_COORDS; else next_part();
            default: close_geom();
        endcase
    endfunction

    function automatic void run_begin(logic [31:0] n);
        coords_left = n;
        if (n == 0) run_end(); else ph = P_X;
    endfunction

    function automatic bit classify(logic [31:0] raw, output logic [31:0] t, output bit z);
        if (raw > wkbp_pkg::ISO_Z_BASE && raw <= wkbp_pkg::ISO_Z_BASE + 6)
        begin
            t = raw - wkbp_pkg::ISO_Z_BASE; z = 1;
        end
        else if (raw[31])
        begin
            t = {1'b0, raw[30:0]}; z = 1;
        end
        else
        begin
            t = raw; z = 0;
        end
        return t >= 1 && t <= 6;
    endfunction

    function automatic void coord_out(logic [63:0] z);
        add_rec(wkbp_pkg::KIND_COORD, x_hold, y_hold, z, cur_z, coord_cnt,
                wkbp_pkg::ERR_NONE);
        coord_cnt++;
        if (coords_left > 0) coords_left--;
        if (coords_left == 0) run_end(); else ph = P_X;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [63:0] v;
        logic [31:0] t;
        bit          z;
        case (ph)
            P_TOP_BO, P_SUB_BO:
            begin
                if (b > 1)
                begin
                    abort_geom(wkbp_pkg::ERR_BYTE_ORD);
                    return;
                end
                le = (b == 1); shf = 0; nbytes = 0;
                ph = (ph == P_TOP_BO) ? P_TOP_TYPE : P_SUB_TYPE;
            end
            P_TOP_TYPE:
            begin
                if (!gather(b, 4, v)) return;
                if (!classify(v[31:0], t, z))
                begin
                    abort_geom(wkbp_pkg::ERR_TYPE);
                    return;
                end
                ttype = t[2:0]; cur_z = z;
                if (t == wkbp_pkg::T_POINT) run_begin(1);
                else if (t == wkbp_pkg::T_LINE) ph = P_NUM_COORDS;
                else if (t == wkbp_pkg::T_POLY) ph = P_NUM_RINGS;
                else ph = P_NUM_PARTS;
            end
            P_SUB_TYPE:
            begin
                if (!gather(b, 4, v)) return;
                if (!classify(v[31:0], t, z))
                begin
                    abort_geom(wkbp_pkg::ERR_TYPE);
                    return;
                end
                if (t + 3 != 32'(ttype))
                begin
                    abort_geom(wkbp_pkg::ERR_SUBTYPE);
                    return;
                end
                cur_z = z;
                if (t == wkbp_pkg::T_POINT) run_begin(1);
                else if (t == wkbp_pkg::T_LINE) ph = P_NUM_COORDS;
                else
                begin
                    add_rec(wkbp_pkg::KIND_PART, 0, 0, 0, 0, ring_cnt, wkbp_pkg::ERR_NONE);
                    ph = P_NUM_RINGS;
                end
            end
            P_NUM_COORDS:
            begin
                if (!gather(b, 4, v)) return;
                if (ttype == wkbp_pkg::T_MLINE)
                begin
                    add_rec(wkbp_pkg::KIND_RING, 0, 0, 0, 0, coord_cnt, wkbp_pkg::ERR_NONE);
                    ring_cnt++;
                end
                run_begin(v[31:0]);
            end
            P_NUM_RINGS:
            begin
                if (!gather(b, 4, v)) return;
                rings_left = v[31:0];
                coords_left = 0;
                if (rings_left == 0) run_end(); else ph = P_RING_COORDS;
            end
            P_RING_COORDS:
            begin
                if (!gather(b, 4, v)) return;
                if (rings_left > 0) rings_left--;
                add_rec(wkbp_pkg::KIND_RING, 0, 0, 0, 0, coord_cnt, wkbp_pkg::ERR_NONE);
                ring_cnt++;
                run_begin(v[31:0]);
            end
            P_NUM_PARTS:
            begin
                if (!gather(b, 4, v)) return;
                parts_left = v[31:0];
                next_part();
            end
            P_X:
            begin
                if (!gather(b, 8, v)) return;
                x_hold = v;
                ph = P_Y;
            end
            P_Y:
            begin
                if (!gather(b, 8, v)) return;
                y_hold = v;
                if (cur_z) ph = P_Z; else coord_out(0);
            end
            P_Z:
            begin
                if (!gather(b, 8, v)) return;
                coord_out(v);
            end
            default:
            begin
                ph = P_IDLE;
                done_flag = 1;
            end
        endcase
    endfunction

    function automatic void predict_word(logic [7:0] b, logic l);
        step_recs = {};
        if (!done_flag) parse_byte(b);
        if (l)
        begin
            if (!done_flag) abort_geom(wkbp_pkg::ERR_TRUNC);
            clear_parser();
        end
        if (step_recs.size() > 0) step_recs[$].last = 1'b1;
        foreach (step_recs[i]) record_q.push_back(step_recs[i]);
    endfunction

    task automatic send_word(logic [7:0] b, logic l);
        while (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        do @(posedge clk); while (in_stall);
        predict_word(b, l);
    endtask

    // Geometry generator.
    logic [7:0] geom_q[$];
    bit         gen_le;
    flaw_t      flaw;

    function automatic void put32(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            geom_q.push_back(gen_le ? v[8 * i +: 8] : v[8 * (3 - i) +: 8]);
    endfunction

    function automatic logic [31:0] pick_count(int hi);
        if (flaw == FLAW_HUGE && $urandom_range(3) == 0) return $urandom;
        return $urandom_range(hi);
    endfunction

    function automatic void put_header(logic [31:0] t, bit top);
        logic [31:0] raw;
        gen_le = $urandom_range(1);
        if (flaw == FLAW_BYTE_ORD && $urandom_range(2) == 0)
            geom_q.push_back(8'($urandom_range(255, 2)));
        else
            geom_q.push_back({7'd0, gen_le});
        case ($urandom_range(2))
            0: raw = t;
            1: raw = t + wkbp_pkg::ISO_Z_BASE;
            default: raw = t | wkbp_pkg::OGC_Z_FLAG;
        endcase
        if (flaw == FLAW_TYPE && $urandom_range(2) == 0)
        begin
            case ($urandom_range(3))
                0: raw = 0;
                1: raw = 7;
                2: raw = wkbp_pkg::ISO_Z_BASE + 7;
                default: raw = $urandom;
            endcase
        end
        else if (!top && flaw == FLAW_SUBTYPE && $urandom_range(1) == 0)
            raw = (t % 6) + 1;
        put32(raw);
    endfunction

    // Coordinates: 2 or 3 doubles; a huge count only gets three before the cut.
    function automatic void put_coords(logic [31:0] n);
        int m;
        m = (n > 4) ? 3 : int'(n);
        for (int i = 0; i < m * 3; i++)
        begin
            if (i % 3 == 2 && $urandom_range(1) == 0) continue;
            for (int k = 0; k < 8; k++)
                geom_q.push_back($urandom_range(3) == 0 ? 8'hFF : 8'($urandom));
        end
    endfunction

    function automatic void put_rings();
        logic [31:0] r, c;
        r = pick_count(3);
        put32(r);
        for (int i = 0; i < ((r > 4) ? 2 : int'(r)); i++)
        begin
            c = pick_count(4);
            put32(c);
            put_coords(c);
        end
    endfunction

    function automatic void build_geometry();
        int          t;
        logic [31:0] n, p;
        geom_q = {};
        case ($urandom_range(19))
            0: flaw = FLAW_BYTE_ORD;
            1: flaw = FLAW_TYPE;
            2: flaw = FLAW_SUBTYPE;
            3, 4: flaw = FLAW_CUT;
            5: flaw = FLAW_HUGE;
            6: flaw = FLAW_TAIL;
            7: flaw = FLAW_NOISE;
            default: flaw = FLAW_NONE;
        endcase
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(12, 1)) geom_q.push_back($urandom);
            return;
        end
        t = $urandom_range(6, 1);
        put_header(t, 1);
        case (t)
            1: put_coords(1);
            2:
            begin
                n = pick_count(4);
                put32(n);
                put_coords(n);
            end
            3: put_rings();
            default:
            begin
                p = pick_count(3);
                put32(p);
                for (int i = 0; i < ((p > 4) ? 2 : int'(p)); i++)
                begin
                    put_header(t - 3, 0);
                    if (t == 4) put_coords(1);
                    else if (t == 5)
                    begin
                        n = pick_count(3);
                        put32(n);
                        put_coords(n);
                    end
                    else put_rings();
                end
            end
        endcase
        if (flaw == FLAW_CUT && geom_q.size() > 1)
            geom_q = geom_q[0 : $urandom_range(geom_q.size() - 2)];
        if (flaw == FLAW_TAIL)
            repeat ($urandom_range(4, 1)) geom_q.push_back($urandom);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // Receiver side: check each accepted record, then choose the next stall.
    initial
    begin
        wkbp_pkg::rec_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (record_q.size() == 0)
                begin
                    $display("%0t: unexpected record, actual kind %0d", $time, record_kind);
                    fail_cnt++;
                end
                else
                begin
                    e = record_q.pop_front();
                    check_field("record_kind", e.kind, record_kind);
                    check_field("geom_type", e.gtype, geom_type);
                    check_field("x_bits", e.x, x_bits);
                    check_field("y_bits", e.y, y_bits);
                    check_field("z_bits", e.z, z_bits);
                    check_field("coord_has_z", e.has_z, coord_has_z);
                    check_field("index_value", e.idx, index_value);
                    check_field("error_code", e.err, error_code);
                    check_field("last_result", e.last, last_result);
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                hold_cnt = 300;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 24);
        end
    end

    row_t tbl[] = '{
        '{8'hFF, 1'b1, 1, wkbp_pkg::KIND_ERROR, wkbp_pkg::ERR_BYTE_ORD},
        '{8'h01, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h07, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b1, 1, wkbp_pkg::KIND_ERROR, wkbp_pkg::ERR_TYPE},
        '{8'h01, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h01, 1'b1, 1, wkbp_pkg::KIND_ERROR, wkbp_pkg::ERR_TRUNC},
        '{8'h01, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h04, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h01, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h01, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h02, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b0, 0, wkbp_pkg::KIND_COORD, wkbp_pkg::ERR_NONE},
        '{8'h00, 1'b1, 1, wkbp_pkg::KIND_ERROR, wkbp_pkg::ERR_SUBTYPE}
    };

    initial
    begin
        int sent;
        clear_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (tbl[i])
        begin
            send_word(tbl[i].b, tbl[i].l);
            if (tbl[i].chk && (step_recs.size() == 0 || step_recs[$].kind !== tbl[i].kind
                               || step_recs[$].err !== tbl[i].err))
            begin
                $display("%0t: directed word %0d, expected kind %0d err %0d", $time, i,
                         tbl[i].kind, tbl[i].err);
                fail_cnt++;
            end
        end
        sent = 0;
        while (sent < 1200)
        begin
            build_geometry();
            if (sent > 600 && calm_from < 0) calm_from = sent;
            calm = (calm_from >= 0 && sent < calm_from + 200);
            if (sent > 300 && !held && hold_cnt == 0)
            begin
                hold_req = 1;
                held = 1;
            end
            if (sent > 900 && !drained)
            begin
                // Let the output side drain completely before the next geometry.
                drained = 1;
                in_valid <= 1'b0;
                wait (record_q.size() == 0);
                @(posedge clk);
            end
            foreach (geom_q[i])
                send_word(geom_q[i], i == geom_q.size() - 1);
            sent += geom_q.size();
        end
        in_valid <= 1'b0;
        wait (record_q.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== wkb_geometry_stream_parser_unit.f =====
sv/wkbp_pkg.sv
sv/wkbp_front.sv
sv/wkbp_queue.sv
sv/wkb_geometry_stream_parser_unit.sv
sv/wkbp_checker.sv
tb/tb_wkb_geometry_stream_parser_unit.sv
